FILE: rtl/sdo_srv_pkg.sv
package sdo_srv_pkg;

    localparam int ENTRIES = 32;
    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    localparam int IN_TDATA_W = 88;
    localparam int IN_TUSER_W = 1;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_TUSER_W = 4;

    localparam logic [10:0] COB_RX_LO = 11'h601;
    localparam logic [10:0] COB_RX_HI = 11'h67F;
    localparam logic [10:0] COB_RX_BASE = 11'h600;
    localparam logic [10:0] COB_TX_BASE = 11'h580;

    localparam logic [7:0] CMD_UPLOAD = 8'h40;
    localparam logic [7:0] CMD_DL4 = 8'h23;
    localparam logic [7:0] CMD_DL2 = 8'h2B;
    localparam logic [7:0] CMD_DL1 = 8'h2F;
    localparam logic [7:0] RESP_ACK = 8'h60;
    localparam logic [7:0] RESP_UP4 = 8'h43;
    localparam logic [7:0] RESP_UP2 = 8'h4B;
    localparam logic [7:0] RESP_UP1 = 8'h4F;

    localparam logic CFG_NODE_ID = 1'b0;
    localparam logic CFG_NODE_STOPPED = 1'b1;

    typedef enum logic [1:0] {
        WID_1 = 2'd0,
        WID_2 = 2'd1,
        WID_4 = 2'd2,
        WID_NONE = 2'd3
    } width_t;

    typedef enum logic [2:0] {
        ST_STORED = 3'd0,
        ST_READ = 3'd1,
        ST_NOT_SDO = 3'd2,
        ST_OTHER_NODE = 3'd3,
        ST_BAD_CMD = 3'd4,
        ST_NOT_STORED = 3'd5,
        ST_READ_FAIL = 3'd6,
        ST_DEFINED = 3'd7
    } status_t;

    typedef struct packed {
        logic locked;
        width_t code;
        logic [15:0] index;
        logic [7:0] sub;
        logic [31:0] data;
    } entry_t;

    typedef struct packed {
        logic any_width;
        width_t code;
        logic [15:0] index;
        logic [7:0] sub;
    } key_t;

    localparam int ENTRY_W = $bits(entry_t);

    function automatic width_t width_of(input logic [7:0] cmd);
        width_t w;
        case (cmd)
            CMD_DL4: w = WID_4;
            CMD_DL2: w = WID_2;
            CMD_DL1: w = WID_1;
            default: w = WID_NONE;
        endcase
        return w;
    endfunction

    function automatic logic [31:0] width_mask(input width_t w);
        logic [31:0] m;
        case (w)
            WID_4: m = 32'hFFFF_FFFF;
            WID_2: m = 32'h0000_FFFF;
            default: m = 32'h0000_00FF;
        endcase
        return m;
    endfunction

    function automatic logic [7:0] upload_cmd(input width_t w);
        logic [7:0] c;
        case (w)
            WID_4: c = RESP_UP4;
            WID_2: c = RESP_UP2;
            default: c = RESP_UP1;
        endcase
        return c;
    endfunction

endpackage

FILE: rtl/sdo_srv_ram.sv
module sdo_srv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/sdo_srv_match.sv
module sdo_srv_match (
    input  logic               valid,
    input  sdo_srv_pkg::entry_t entry,
    input  sdo_srv_pkg::key_t   key,
    output logic               hit
);

    assign hit = valid && !entry.locked
               && (entry.index == key.index)
               && (entry.sub == key.sub)
               && (key.any_width || (entry.code == key.code));

endmodule

FILE: rtl/sdo_expedited_server_top.sv
// SDO expedited server.
// The slave stream carries one request per transfer: a received CAN frame
// (tuser = 0) or a local definition of a dictionary slot (tuser = 1).
// The master stream returns exactly one result per request, with the
// status and reply flag in tuser and the reply frame in tdata.
// The user must write configuration through cfg_wr_en, cfg_index and
// cfg_data only while the block is idle; the block does not enforce this.
// Register 0 is the node id, register 1 stops it. A request is taken
// only when the block is idle. Uploads and downloads walk the dictionary
// one slot per cycle through a single compare unit: decode, scan of every
// slot, drain, result; other requests go from decode straight to the
// result. The block is ready again in the cycle after the result is
// loaded, and takes no new request while a request is still in work.
// The result sits in an output register, so the next request is taken
// while it waits to be read; a stalled receiver holds the block only once
// a second result is ready.
// Reset clears all slot valid bits, sets node id to 1 and runs the node.
module sdo_expedited_server_top (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    // cob_id, slot, locked, byte0 .. byte7, zero padding
    input  logic [sdo_srv_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
    // opcode
    input  logic [sdo_srv_pkg::IN_TUSER_W-1:0]    s_axis_tuser,
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    // resp_cob_id, resp_byte0 .. resp_byte7, zero padding
    output logic [sdo_srv_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
    // status, respond
    output logic [sdo_srv_pkg::OUT_TUSER_W-1:0]   m_axis_tuser,
    input  logic                                  cfg_wr_en,
    input  logic                                  cfg_index,
    input  logic [6:0]                            cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DECODE = 5'b00010,
        S_SCAN   = 5'b00100,
        S_DRAIN  = 5'b01000,
        S_RESULT = 5'b10000
    } state_t;

    localparam int IDX_W = sdo_srv_pkg::IDX_W;
    localparam int ENTRIES = sdo_srv_pkg::ENTRIES;

    state_t state_reg, state_next;

    logic [6:0] node_id_reg;
    logic node_stopped_reg;

    logic opcode_reg;
    logic [10:0] cob_reg;
    logic [4:0] slot_reg;
    logic locked_reg;
    logic [7:0] cmd_reg;
    logic [15:0] idx_reg;
    logic [7:0] sub_reg;
    logic [31:0] data_reg;

    logic [IDX_W-1:0] cnt_reg;
    logic [IDX_W-1:0] eval_addr_reg;
    logic pend_reg;
    logic hit_reg;
    sdo_srv_pkg::entry_t hit_entry_reg;
    logic upload_reg;
    logic scan_reg;
    sdo_srv_pkg::status_t status_reg;
    logic [ENTRIES-1:0] valid_reg;

    logic out_valid_reg;
    logic [sdo_srv_pkg::OUT_TDATA_W-1:0] out_tdata_reg;
    logic [sdo_srv_pkg::OUT_TUSER_W-1:0] out_tuser_reg;

    sdo_srv_pkg::width_t w;
    logic def_ok;
    sdo_srv_pkg::status_t dec_status;
    logic dec_scan;

    logic ram_we;
    logic [IDX_W-1:0] ram_waddr;
    sdo_srv_pkg::entry_t ram_wentry;
    logic [sdo_srv_pkg::ENTRY_W-1:0] ram_rdata;
    sdo_srv_pkg::entry_t rd_entry;
    sdo_srv_pkg::key_t key;
    logic match;

    logic accept;
    logic load_out;
    sdo_srv_pkg::status_t fin_status;
    logic respond;
    logic [10:0] resp_cob;
    logic [7:0] rb0;
    logic [15:0] ridx;
    logic [7:0] rsub;
    logic [31:0] rdat;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    assign w = sdo_srv_pkg::width_of(cmd_reg);
    assign def_ok = (w != sdo_srv_pkg::WID_NONE) && (32'(slot_reg) < ENTRIES);

    always_comb
    begin
        dec_status = sdo_srv_pkg::ST_BAD_CMD;
        dec_scan = 1'b0;
        if (opcode_reg)
        begin
            dec_status = def_ok ? sdo_srv_pkg::ST_DEFINED : sdo_srv_pkg::ST_BAD_CMD;
        end
        else if (node_stopped_reg || (cob_reg < sdo_srv_pkg::COB_RX_LO)
                 || (cob_reg > sdo_srv_pkg::COB_RX_HI))
        begin
            dec_status = sdo_srv_pkg::ST_NOT_SDO;
        end
        else if (cob_reg != (sdo_srv_pkg::COB_RX_BASE + 11'(node_id_reg)))
        begin
            dec_status = sdo_srv_pkg::ST_OTHER_NODE;
        end
        else if ((cmd_reg == sdo_srv_pkg::CMD_UPLOAD) || (w != sdo_srv_pkg::WID_NONE))
        begin
            dec_scan = 1'b1;
        end
    end

    assign key.any_width = upload_reg;
    assign key.code = w;
    assign key.index = idx_reg;
    assign key.sub = sub_reg;

    assign rd_entry = sdo_srv_pkg::entry_t'(ram_rdata);

    sdo_srv_match u_match (
        .valid (pend_reg && valid_reg[eval_addr_reg]),
        .entry (rd_entry),
        .key   (key),
        .hit   (match)
    );

    assign ram_we = ((state_reg == S_DECODE) && opcode_reg && def_ok)
                  || (pend_reg && match && !upload_reg);
    assign ram_waddr = (state_reg == S_DECODE) ? IDX_W'(slot_reg) : eval_addr_reg;
    assign ram_wentry.locked = opcode_reg ? locked_reg : 1'b0;
    assign ram_wentry.code = w;
    assign ram_wentry.index = idx_reg;
    assign ram_wentry.sub = sub_reg;
    assign ram_wentry.data = data_reg & sdo_srv_pkg::width_mask(w);

    sdo_srv_ram #(
        .WIDTH (sdo_srv_pkg::ENTRY_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wentry),
        .raddr (cnt_reg),
        .rdata (ram_rdata)
    );

    assign load_out = (state_reg == S_RESULT) && (!out_valid_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                state_next = dec_scan ? S_SCAN : S_RESULT;
            end
            S_SCAN:
            begin
                if (cnt_reg == IDX_W'(ENTRIES - 1))
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_RESULT;
            end
            S_RESULT:
            begin
                if (load_out)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        fin_status = status_reg;
        if (scan_reg)
        begin
            if (upload_reg)
            begin
                fin_status = hit_reg ? sdo_srv_pkg::ST_READ : sdo_srv_pkg::ST_READ_FAIL;
            end
            else
            begin
                fin_status = hit_reg ? sdo_srv_pkg::ST_STORED : sdo_srv_pkg::ST_NOT_STORED;
            end
        end
    end

    assign respond = (fin_status == sdo_srv_pkg::ST_READ)
                  || (fin_status == sdo_srv_pkg::ST_STORED);
    assign resp_cob = respond ? (sdo_srv_pkg::COB_TX_BASE + 11'(node_id_reg)) : 11'd0;
    assign rb0 = (fin_status == sdo_srv_pkg::ST_READ) ?
                 sdo_srv_pkg::upload_cmd(hit_entry_reg.code) :
                 ((fin_status == sdo_srv_pkg::ST_STORED) ? sdo_srv_pkg::RESP_ACK : 8'd0);
    assign ridx = respond ? idx_reg : 16'd0;
    assign rsub = respond ? sub_reg : 8'd0;
    assign rdat = (fin_status == sdo_srv_pkg::ST_READ) ? hit_entry_reg.data : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            node_id_reg <= 7'd1;
            node_stopped_reg <= 1'b0;
            valid_reg <= '0;
            cnt_reg <= '0;
            eval_addr_reg <= '0;
            pend_reg <= 1'b0;
            hit_reg <= 1'b0;
            upload_reg <= 1'b0;
            scan_reg <= 1'b0;
            status_reg <= sdo_srv_pkg::ST_BAD_CMD;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (cfg_wr_en)
            begin
                case (cfg_index)
                    sdo_srv_pkg::CFG_NODE_ID: node_id_reg <= cfg_data;
                    sdo_srv_pkg::CFG_NODE_STOPPED: node_stopped_reg <= cfg_data[0];
                    default: node_id_reg <= node_id_reg;
                endcase
            end

            if (state_reg == S_DECODE)
            begin
                status_reg <= dec_status;
                scan_reg <= dec_scan;
                upload_reg <= (cmd_reg == sdo_srv_pkg::CMD_UPLOAD);
                hit_reg <= 1'b0;
                cnt_reg <= '0;
                if (opcode_reg && def_ok)
                begin
                    valid_reg[IDX_W'(slot_reg)] <= 1'b1;
                end
            end
            else if ((state_reg == S_SCAN) && (cnt_reg != IDX_W'(ENTRIES - 1)))
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end

            pend_reg <= (state_reg == S_SCAN);
            eval_addr_reg <= cnt_reg;
            if (pend_reg && match)
            begin
                hit_reg <= 1'b1;
            end

            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            opcode_reg <= s_axis_tuser[0];
            cob_reg <= s_axis_tdata[10:0];
            slot_reg <= s_axis_tdata[15:11];
            locked_reg <= s_axis_tdata[16];
            cmd_reg <= s_axis_tdata[24:17];
            idx_reg <= {s_axis_tdata[40:33], s_axis_tdata[32:25]};
            sub_reg <= s_axis_tdata[48:41];
            data_reg <= s_axis_tdata[80:49];
        end
        if (pend_reg && match && upload_reg)
        begin
            hit_entry_reg <= rd_entry;
        end
        if (load_out)
        begin
            out_tuser_reg <= {respond, fin_status};
            out_tdata_reg <= {5'd0, rdat[31:24], rdat[23:16], rdat[15:8], rdat[7:0],
                              rsub, ridx[15:8], ridx[7:0], rb0, resp_cob};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata = out_tdata_reg;
    assign m_axis_tuser = out_tuser_reg;

endmodule
